@@ sv/gocl_pkg.sv @@
// Package with shared constants for the gyro offset calibration and low-pass core.
`default_nettype none
package gocl_pkg;

  // Field widths.
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned QNEED_W = 8;
  localparam int unsigned DISC_W  = 10;
  localparam int unsigned STATE_W = 32;

  // Default averaging length as a power of two.
  localparam int unsigned AVG_LOG2_DEFAULT = 8;

  // Register reset values.
  localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd9830;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd5;
  localparam logic [QNEED_W-1:0] QNEED_RESET = 8'd30;
  localparam logic [DISC_W-1:0]  DISC_RESET  = 10'd100;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_FILTER_COEF   = 2'd0;
  localparam logic [1:0] REG_QUIET_LIMIT   = 2'd1;
  localparam logic [1:0] REG_QUIET_NEEDED  = 2'd2;
  localparam logic [1:0] REG_DISCARD_COUNT = 2'd3;

  // Calibration phase codes.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_SETTLE  = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;
  localparam logic [1:0] PH_SUM     = 2'd3;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

endpackage
`default_nettype wire

@@ sv/gyro_offset_calibrate_lowpass_core.sv @@
// Gyro offset subtraction, first-order low-pass filter and offset calibration.
//
// Channel   Direction  Width  Contents
// s_axis    in         48+1   tdata: x, y, z raw rates; tuser: command
// m_axis    out        48+2   tdata: x, y, z rates; tuser: calibrating, done
// apb       in/out     32     four configuration registers at 0x0, 0x4, 0x8, 0xC
//
// A word passes an input register, then the combinational filter and
// calibration logic (one 32x17 and one 16x16 multiply per axis) into the
// output register. One word is accepted every cycle while m_axis drains. A
// stall on m_axis holds both registers; the input register still takes a word
// whenever it is empty or moving on. Reset clears the valid flags and all
// architectural state and restores the register defaults.
`default_nettype none
module gyro_offset_calibrate_lowpass_core
  import gocl_pkg::*;
#(
  parameter int unsigned AVG_LOG2 = AVG_LOG2_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  wire logic [0:0]  s_axis_tuser_i,   // command
  // Output stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // rate_x, rate_y, rate_z
  output logic [1:0]       m_axis_tuser_o,   // calibrating, calibration_done
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned SUM_W = RATE_W + AVG_LOG2;
  localparam int unsigned CNT_W = (AVG_LOG2 + 1 > 11) ? AVG_LOG2 + 1 : 11;
  localparam logic [CNT_W-1:0] AVG_LEN = CNT_W'(1) << AVG_LOG2;

  // Configuration registers.
  logic [COEF_W-1:0]  coef_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [QNEED_W-1:0] qneed_q;
  logic [DISC_W-1:0]  disc_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= COEF_RESET;
      limit_q <= LIMIT_RESET;
      qneed_q <= QNEED_RESET;
      disc_q  <= DISC_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FILTER_COEF:   coef_q  <= pwdata[COEF_W-1:0];
        REG_QUIET_LIMIT:   limit_q <= pwdata[LIMIT_W-1:0];
        REG_QUIET_NEEDED:  qneed_q <= pwdata[QNEED_W-1:0];
        REG_DISCARD_COUNT: disc_q  <= pwdata[DISC_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_FILTER_COEF:   prdata = {16'd0, coef_q};
      REG_QUIET_LIMIT:   prdata = {17'd0, limit_q};
      REG_QUIET_NEEDED:  prdata = {24'd0, qneed_q};
      REG_DISCARD_COUNT: prdata = {22'd0, disc_q};
      default:           prdata = 32'd0;
    endcase
  end

  // Pipeline handshake: the output register frees up or is taken this cycle.
  logic in_v_q;
  logic out_v_q;
  logic advance;
  logic in_take;
  logic commit;

  assign advance         = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_v_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = in_v_q && advance;

  // Input register.
  logic              cmd_q;
  logic [RATE_W-1:0] raw_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_take) begin
      in_v_q <= 1'b1;
    end else if (advance) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= s_axis_tuser_i[0];
      raw_q[0] <= s_axis_tdata_i[15:0];
      raw_q[1] <= s_axis_tdata_i[31:16];
      raw_q[2] <= s_axis_tdata_i[47:32];
    end
  end

  // Architectural state.
  logic signed [STATE_W-1:0] state_q [3];
  logic [RATE_W-1:0]         offset_q [3];
  logic [RATE_W-1:0]         prev_q [3];
  logic signed [SUM_W-1:0]   sum_q [3];
  logic [1:0]                phase_q;
  logic [QNEED_W-1:0]        quiet_q;
  logic [CNT_W-1:0]          count_q;

  logic signed [STATE_W-1:0] state_d [3];
  logic [RATE_W-1:0]         offset_d [3];
  logic [RATE_W-1:0]         prev_d [3];
  logic signed [SUM_W-1:0]   sum_d [3];
  logic [1:0]                phase_d;
  logic [QNEED_W-1:0]        quiet_d;
  logic [CNT_W-1:0]          count_d;

  // Per-axis filter datapath.
  logic [16:0]               coef_comp;
  logic signed [49:0]        prod_s [3];
  logic signed [49:0]        prod_x [3];
  logic signed [49:0]        acc [3];
  logic [RATE_W-1:0]         xin [3];
  logic signed [STATE_W-1:0] snew [3];
  logic [RATE_W-1:0]         y [3];
  logic signed [16:0]        diff [3];
  logic [16:0]               mag [3];
  logic                      quiet;

  assign coef_comp = 17'h10000 - {1'b0, coef_q};

  always_comb begin
    quiet = 1'b1;
    for (int i = 0; i < 3; i++) begin
      xin[i]    = raw_q[i] - offset_q[i];
      prod_s[i] = $signed({{18{state_q[i][STATE_W-1]}}, state_q[i]})
                  * $signed({33'd0, coef_comp});
      prod_x[i] = $signed({{34{xin[i][RATE_W-1]}}, xin[i]})
                  * $signed({34'd0, coef_q});
      acc[i]    = prod_s[i] + (prod_x[i] <<< 16);
      // Floor shift by 16 is a plain bit select.
      snew[i]   = acc[i][47:16];
      // Round toward zero: bump negative values that have a fraction.
      y[i]      = snew[i][31:16]
                  + {15'd0, (snew[i][31] && (snew[i][15:0] != 16'd0))};
      diff[i]   = $signed({y[i][RATE_W-1], y[i]}) - $signed({prev_q[i][RATE_W-1], prev_q[i]});
      mag[i]    = diff[i][16] ? 17'(-diff[i]) : 17'(diff[i]);
      if (mag[i] > {2'd0, limit_q}) begin
        quiet = 1'b0;
      end
    end
  end

  // Calibration sequencing and next state.
  logic [QNEED_W-1:0]      quiet_inc;
  logic [CNT_W-1:0]        count_inc;
  logic signed [SUM_W-1:0] sum_new [3];
  logic                    do_sum;
  logic                    done;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      state_d[i]  = state_q[i];
      offset_d[i] = offset_q[i];
      prev_d[i]   = prev_q[i];
      sum_d[i]    = sum_q[i];
      sum_new[i]  = sum_q[i] + SUM_W'($signed(y[i]));
    end
    phase_d   = phase_q;
    quiet_d   = quiet_q;
    count_d   = count_q;
    quiet_inc = quiet_q + 1'b1;
    count_inc = count_q + 1'b1;
    do_sum    = 1'b0;
    done      = 1'b0;

    if (cmd_q == CMD_START) begin
      // Start keeps the filter and restarts calibration from scratch.
      for (int i = 0; i < 3; i++) begin
        offset_d[i] = '0;
        prev_d[i]   = '0;
        sum_d[i]    = '0;
      end
      quiet_d = '0;
      count_d = '0;
      phase_d = PH_SETTLE;
    end else begin
      for (int i = 0; i < 3; i++) begin
        state_d[i] = snew[i];
        prev_d[i]  = y[i];
      end
      case (phase_q)
        PH_SETTLE: begin
          if (quiet) begin
            quiet_d = quiet_inc;
            if (quiet_inc == '0 || quiet_inc >= qneed_q) begin
              phase_d = PH_DISCARD;
              count_d = '0;
            end
          end
        end
        PH_DISCARD: begin
          if (count_q < CNT_W'(disc_q)) begin
            count_d = count_inc;
          end else begin
            // Last discard step already counted: this sample is summed first.
            do_sum    = 1'b1;
            count_inc = CNT_W'(1);
          end
        end
        PH_SUM: begin
          do_sum = 1'b1;
        end
        default: ;
      endcase

      if (do_sum) begin
        phase_d = PH_SUM;
        count_d = count_inc;
        for (int i = 0; i < 3; i++) begin
          sum_d[i] = sum_new[i];
        end
        if (count_inc >= AVG_LEN) begin
          for (int i = 0; i < 3; i++) begin
            offset_d[i] = sum_new[i][AVG_LOG2 +: RATE_W];
            sum_d[i]    = '0;
          end
          count_d = '0;
          quiet_d = '0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
    end
  end

  // State update on each committed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        state_q[i]  <= '0;
        offset_q[i] <= '0;
        prev_q[i]   <= '0;
        sum_q[i]    <= '0;
      end
      phase_q <= PH_IDLE;
      quiet_q <= '0;
      count_q <= '0;
    end else if (commit) begin
      for (int i = 0; i < 3; i++) begin
        state_q[i]  <= state_d[i];
        offset_q[i] <= offset_d[i];
        prev_q[i]   <= prev_d[i];
        sum_q[i]    <= sum_d[i];
      end
      phase_q <= phase_d;
      quiet_q <= quiet_d;
      count_q <= count_d;
    end
  end

  // Output register.
  logic [47:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (cmd_q == CMD_START) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {y[2], y[1], y[0]};
      end
      out_user_q <= {done, (phase_d != PH_IDLE)};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // A finished calibration never reports itself as still running.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0])
    else $error("calibration_done with calibrating set");

  // Counters are idle outside of calibration.
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> quiet_q == '0 && count_q == '0)
    else $error("counters not clear while idle");

  // The sample counter stays clear while settling.
  a_settle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SETTLE |-> count_q == '0)
    else $error("sample counter running while settling");

  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  // A word that waits on the output keeps its payload until taken.
  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output word changed");

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the gyro offset calibration and low-pass core.
`timescale 1ns / 100ps

module testbench;
  import gocl_pkg::*;

  localparam int unsigned AVG_SHIFT = AVG_LOG2_DEFAULT;
  localparam int unsigned STALL_LIMIT = 2000;

  // One input word: command in tuser, three raw axis rates in tdata.
  typedef struct packed {
    logic            cmd;
    logic [2:0][15:0] raw;
  } gyro_word_t;

  // One output word: flags in tuser, three corrected rates in tdata.
  typedef struct packed {
    logic            done;
    logic            calibrating;
    logic [2:0][15:0] rate;
  } rate_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // gyro_x_raw, gyro_y_raw, gyro_z_raw
  logic [0:0]  s_axis_tuser_i = '0;   // command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // rate_x, rate_y, rate_z
  logic [1:0]  m_axis_tuser_o;        // calibrating, calibration_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gyro_offset_calibrate_lowpass_core #(
    .AVG_LOG2(AVG_SHIFT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be sent and rate words still owed by the core.
  gyro_word_t gyro_backlog[$];
  rate_word_t rate_expect_q[$];
  gyro_word_t in_flight;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int words_sent = 0;
  int starts_sent = 0;
  int results_seen = 0;
  int cal_done_seen = 0;
  int stall_cycles = 0;

  // Shadow copy of the configuration registers.
  logic [COEF_W-1:0]  cfg_coef = COEF_RESET;
  logic [LIMIT_W-1:0] cfg_limit = LIMIT_RESET;
  logic [QNEED_W-1:0] cfg_qneed = QNEED_RESET;
  logic [DISC_W-1:0]  cfg_discard = DISC_RESET;

  // Shadow copy of the filter and calibration state.
  int                 lp_state[3] = '{0, 0, 0};
  logic signed [15:0] axis_bias[3] = '{16'sd0, 16'sd0, 16'sd0};
  int                 last_rate[3] = '{0, 0, 0};
  longint             bias_sum[3] = '{0, 0, 0};
  logic [1:0]         cal_phase = PH_IDLE;
  logic [7:0]         quiet_cnt = '0;
  int                 cal_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_calibration();
    int i;
    for (i = 0; i < 3; i++) begin
      axis_bias[i] = '0;
      last_rate[i] = 0;
      bias_sum[i] = 0;
    end
    quiet_cnt = '0;
    cal_count = 0;
  endfunction

  // Offset subtraction, filter update and calibration step for one word.
  function automatic rate_word_t predict_rates(input gyro_word_t w);
    rate_word_t         r;
    logic signed [15:0] x;
    longint             prod;
    longint             s;
    int                 yv[3];
    int                 d;
    int                 i;
    bit                 quiet;
    r = '0;
    quiet = 1'b1;
    if (w.cmd == CMD_START) begin
      clear_calibration();
      cal_phase = PH_SETTLE;
      r.calibrating = 1'b1;
      return r;
    end
    for (i = 0; i < 3; i++) begin
      x = $signed(w.raw[i]) - axis_bias[i];
      prod = longint'(lp_state[i]) * (64'sd65536 - longint'(cfg_coef))
           + longint'(x) * longint'(cfg_coef) * 64'sd65536;
      s = prod >>> 16;
      lp_state[i] = int'(s);
      // Rate output is the Q16.16 state truncated toward zero.
      if (s >= 0) yv[i] = int'(s >>> 16);
      else yv[i] = -int'((-s) >>> 16);
      d = yv[i] - last_rate[i];
      if (d < 0) d = -d;
      if (d > int'(cfg_limit)) quiet = 1'b0;
      last_rate[i] = yv[i];
      r.rate[i] = yv[i][15:0];
    end
    case (cal_phase)
      PH_SETTLE: begin
        if (quiet) begin
          quiet_cnt = quiet_cnt + 8'd1;
          if (quiet_cnt == 8'd0 || quiet_cnt >= cfg_qneed) begin
            cal_phase = PH_DISCARD;
            cal_count = 0;
          end
        end
      end
      PH_DISCARD: begin
        if (cal_count < int'(cfg_discard)) begin
          cal_count++;
        end else begin
          // The word that ends the discard stretch is the first one summed.
          cal_phase = PH_SUM;
          cal_count = 0;
        end
      end
      default: ;
    endcase
    if (cal_phase == PH_SUM) begin
      for (i = 0; i < 3; i++) bias_sum[i] += yv[i];
      cal_count++;
      if (cal_count >= (1 << AVG_SHIFT)) begin
        for (i = 0; i < 3; i++) begin
          axis_bias[i] = 16'(bias_sum[i] >>> AVG_SHIFT);
          bias_sum[i] = 0;
        end
        cal_count = 0;
        quiet_cnt = '0;
        cal_phase = PH_IDLE;
        r.done = 1'b1;
      end
    end
    r.calibrating = (cal_phase != PH_IDLE);
    return r;
  endfunction

  // Sender: presents backlog words and predicts each one as it is accepted.
  always @(posedge clk_i) begin : gyro_driver
    logic fire;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      fire = s_axis_tvalid_i && s_axis_tready_o;
      if (fire) begin
        rate_expect_q.push_back(predict_rates(in_flight));
        words_sent++;
        if (in_flight.cmd == CMD_START) starts_sent++;
      end
      if (!s_axis_tvalid_i || fire) begin
        if (gyro_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_flight = gyro_backlog.pop_front();
          s_axis_tdata_i <= in_flight.raw;
          s_axis_tuser_i <= in_flight.cmd;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and field-by-field comparison.
  always @(posedge clk_i) begin : rate_monitor
    rate_word_t want;
    int i;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        if (m_axis_tuser_o[1]) cal_done_seen++;
        if (rate_expect_q.size() == 0) begin
          report_mismatch("rate word arrived with none expected");
        end else begin
          want = rate_expect_q.pop_front();
          for (i = 0; i < 3; i++) begin
            if (m_axis_tdata_o[16*i +: 16] !== want.rate[i])
              report_mismatch($sformatf("axis %0d rate got %0d want %0d", i,
                $signed(m_axis_tdata_o[16*i +: 16]), $signed(want.rate[i])));
          end
          if (m_axis_tuser_o[0] !== want.calibrating)
            report_mismatch($sformatf("calibrating got %b want %b",
              m_axis_tuser_o[0], want.calibrating));
          if (m_axis_tuser_o[1] !== want.done)
            report_mismatch($sformatf("calibration_done got %b want %b",
              m_axis_tuser_o[1], want.done));
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles in which neither stream moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FILTER_COEF:   cfg_coef = value[COEF_W-1:0];
      REG_QUIET_LIMIT:   cfg_limit = value[LIMIT_W-1:0];
      REG_QUIET_NEEDED:  cfg_qneed = value[QNEED_W-1:0];
      REG_DISCARD_COUNT: cfg_discard = value[DISC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input int coef, input int limit, input int qneed,
                               input int discard);
    write_register(REG_FILTER_COEF, coef);
    write_register(REG_QUIET_LIMIT, limit);
    write_register(REG_QUIET_NEEDED, qneed);
    write_register(REG_DISCARD_COUNT, discard);
  endtask

  // Blocks until every queued word is sent and every rate word has arrived.
  task automatic wait_drained();
    @(posedge clk_i);
    while (gyro_backlog.size() != 0 || rate_expect_q.size() != 0 || s_axis_tvalid_i)
      @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] gx, input logic [15:0] gy,
                             input logic [15:0] gz);
    gyro_word_t w;
    w.cmd = CMD_SAMPLE;
    w.raw = {gz, gy, gx};
    gyro_backlog.push_back(w);
  endtask

  task automatic push_start();
    gyro_word_t w;
    w.cmd = CMD_START;
    w.raw = {16'($urandom), $urandom};
    gyro_backlog.push_back(w);
  endtask

  function automatic logic [15:0] edge_or_random();
    case ($urandom_range(3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // A calibration run: an optional start, then samples near a per-axis bias with
  // small jitter, some full-range outliers and early restarts, then a tail of
  // extreme and random samples that exercise the stored offsets.
  task automatic queue_calibration_run(input bit with_start, input int n,
                                       input int span, input int jitter,
                                       input int outlier_pct, input int restart_pct,
                                       input int tail);
    logic [15:0] bias[3];
    logic [15:0] v[3];
    int i;
    int k;
    int pick;
    if (with_start) push_start();
    for (k = 0; k < 3; k++) bias[k] = 16'($urandom_range(2 * span) - span);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (i < n / 10 && pick < restart_pct) begin
        push_start();
      end else if (pick >= 100 - outlier_pct) begin
        push_sample(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        for (k = 0; k < 3; k++)
          v[k] = bias[k] + 16'($urandom_range(2 * jitter) - jitter);
        push_sample(v[0], v[1], v[2]);
      end
    end
    for (i = 0; i < tail; i++)
      push_sample(edge_or_random(), edge_or_random(), edge_or_random());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults, no idling: extremes, start and restart, then a full
    // calibration with the default quiet and discard counts.
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (3) push_sample(16'h7FFF, 16'h8000, 16'h0000);
    repeat (3) push_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    push_sample(16'h5555, 16'hAAAA, 16'h0001);
    push_sample(16'hAAAA, 16'h5555, 16'hFFFE);
    push_start();
    repeat (2) push_sample(16'h0000, 16'h0000, 16'h0000);
    push_start();
    repeat (2) push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (2) push_sample(16'h8000, 16'h8000, 16'h8000);
    queue_calibration_run(1'b1, 500, 30000, 2, 1, 0, 10);
    wait_drained();

    // Frozen filter, zero limit, one quiet word, no discard; sender idles.
    src_idle_pct = 53;
    sink_stall_pct = 0;
    set_registers(0, 0, 1, 0);
    queue_calibration_run(1'b1, 280, 30000, 3, 10, 3, 10);
    wait_drained();

    // Near pass-through filter with full-range swings, widest limit and longest
    // counts; receiver stalls. Calibration is left unfinished.
    src_idle_pct = 0;
    sink_stall_pct = 53;
    set_registers(65535, 32767, 255, 1023);
    queue_calibration_run(1'b1, 80, 30000, 3, 60, 3, 10);
    wait_drained();

    // Registers change mid-calibration: a zero quiet count takes over the
    // unfinished run, which then completes. Both sides idle.
    src_idle_pct = 37;
    sink_stall_pct = 37;
    set_registers($urandom_range(40000, 12000), 3, 0, 5);
    queue_calibration_run(1'b0, 360, 30000, 1, 2, 0, 10);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d words (%0d calibration starts) under four register settings",
             words_sent, starts_sent);
    $display("and idle mixes; checked %0d rate words, %0d calibrations completed.",
             results_seen, cal_done_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
